[sv/esc_pkg.sv]
`timescale 1ns / 1ps
// Package for the epoch-seconds-to-calendar block: widths, constants, calendar helpers.
package esc_pkg;

  localparam int SECS_W = 32;   // input word width
  localparam int DAYS_W = 16;   // day count since epoch fits 16 bits (max 49710)

  // Compare-subtract step counts, set by the quotient widths
  localparam int N_DAY  = 16;   // seconds / 86400, below 2**16
  localparam int N_HOUR = 5;    // second of day / 3600, below 2**5
  localparam int N_MIN  = 6;    // second of hour / 60, below 2**6
  localparam int N_WDAY = 13;   // (days + 4) / 7, below 2**13

  // First subtrahend of each split: the divisor shifted up by steps - 1
  localparam logic [SECS_W-1:0] STEP_DAY  = 32'd2831155200;  // 86400 * 2**15
  localparam logic [SECS_W-1:0] STEP_HOUR = 32'd57600;       // 3600 * 2**4
  localparam logic [SECS_W-1:0] STEP_MIN  = 32'd1920;        // 60 * 2**5
  localparam logic [SECS_W-1:0] STEP_WDAY = 32'd28672;       // 7 * 2**12

  localparam logic [DAYS_W-1:0] WDAY_BIAS = 16'd4;   // 1970-01-01 was a Thursday
  localparam logic [DAYS_W-1:0] YEAR_LEN  = 16'd365;
  localparam logic [DAYS_W-1:0] LEAP_LEN  = 16'd366;

  localparam logic [7:0] YEAR_MAX_OFF  = 8'd136;  // 2106
  localparam logic [7:0] NO_LEAP_OFF   = 8'd130;  // 2100, a century not divisible by 400
  localparam logic [1:0] EPOCH_MOD4    = 2'd2;    // 1970 mod 4

  localparam logic [3:0] MON_JAN = 4'd0;
  localparam logic [3:0] MON_FEB = 4'd1;
  localparam logic [3:0] MON_DEC = 4'd11;

  // Result of the shared compare-subtract unit
  typedef struct packed {
    logic              ge;
    logic [SECS_W-1:0] diff;
  } sub_res_t;

  // Leap year from the offset to 1970. Over 1970..2106 the only century is
  // 2100 (2000 is divisible by 400 and stays leap).
  function automatic logic is_leap(input logic [7:0] off);
    logic [7:0] y4;
    y4 = off + {6'd0, EPOCH_MOD4};
    return (y4[1:0] == 2'd0) && (off != NO_LEAP_OFF);
  endfunction

  // Month length, index from 0 for January
  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    case (mon)
      4'd0:    len = 5'd31;
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      4'd11:   len = 5'd31;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

[sv/esc_sub.sv]
`timescale 1ns / 1ps
// Shared compare-and-subtract unit of the calendar sequencer.
module esc_sub
  import esc_pkg::*;
(
  input  logic [SECS_W-1:0] a,
  input  logic [SECS_W-1:0] b,
  output sub_res_t          res
);

  logic [SECS_W:0] wide;

  // borrow out of the top bit means a < b
  assign wide     = {1'b0, a} - {1'b0, b};
  assign res.diff = wide[SECS_W-1:0];
  assign res.ge   = ~wide[SECS_W];

endmodule

[sv/epoch_seconds_to_calendar.sv]
`timescale 1ns / 1ps
// Top level: seconds since 1970 broken into time of day, weekday and calendar date.
//
// Takes one 32-bit word of seconds since 1970-01-01 00:00:00 UTC and returns
// second, minute, hour, weekday (1 = Sunday), year minus 1970, month (1..12)
// and day of month (1..31), Gregorian leap rule, so 2100 is a common year.
// Every 32-bit value is legal; the top of the range lands in February 2106.
// All arithmetic goes through one 32-bit compare-subtract unit driven by a
// small sequencer. Day count, time of day and weekday come from compare and
// subtract against shifted constants, one step per cycle: 86400 * 2**k for
// k = 15..0 gives the day count and the second of the day, 3600 * 2**k for
// k = 4..0 the hour, 60 * 2**k for k = 5..0 minute and second, and 7 * 2**k
// for k = 12..0 on the day count plus four the weekday, 40 steps in all.
// The scaled constant sits in a register that shifts right one place a step.
// Then the year is found one year per cycle and the month one month per
// cycle. A new word is taken only from idle, once the last word is through
// the month search. time_stall is high while a word is being worked on. A
// finished result sits in its own output register, so a new word is taken
// while the previous result still waits on date_stall; the block only holds
// at the end of a word if the old result has not yet gone.
module epoch_seconds_to_calendar
  import esc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // input word
  input  logic                time_valid,
  output logic                time_stall,
  input  logic [SECS_W-1:0]   epoch_seconds,
  // result word
  output logic                date_valid,
  input  logic                date_stall,
  output logic [5:0]          second,
  output logic [5:0]          minute,
  output logic [4:0]          hour,
  output logic [2:0]          weekday,
  output logic [7:0]          year_offset,
  output logic [3:0]          month,
  output logic [4:0]          day_of_month
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DIV   = 4'b0010,   // constant compare-subtract splits
    ST_YEAR  = 4'b0100,   // year stepping
    ST_MONTH = 4'b1000    // month stepping
  } state_t;

  // which split is running
  typedef enum logic [3:0] {
    PH_DAY  = 4'b0001,
    PH_HOUR = 4'b0010,
    PH_MIN  = 4'b0100,
    PH_WDAY = 4'b1000
  } phase_t;

  state_t            state;
  phase_t            phase;
  logic [SECS_W-1:0] rest;      // value being reduced
  logic [SECS_W-1:0] dsr;       // scaled constant, halves each step
  logic [DAYS_W-1:0] quo;       // quotient bits, MSB first
  logic [3:0]        cnt;       // steps left, minus one
  logic [DAYS_W-1:0] days;      // days left to place
  logic [7:0]        yoff;
  logic [3:0]        mon;
  logic [5:0]        work_sec;
  logic [5:0]        work_min;
  logic [4:0]        work_hour;
  logic [2:0]        work_wday;

  logic [SECS_W-1:0] sub_a;
  logic [SECS_W-1:0] sub_b;
  sub_res_t          sub_res;
  logic              leap;
  logic [SECS_W-1:0] rest_next;
  logic [DAYS_W-1:0] quo_next;
  logic              month_done;
  logic              out_free;

  esc_sub u_sub (
    .a   (sub_a),
    .b   (sub_b),
    .res (sub_res)
  );

  assign leap = is_leap(yoff);

  // one split step: take the scaled constant off if it fits
  assign rest_next = sub_res.ge ? sub_res.diff : rest;
  assign quo_next  = {quo[DAYS_W-2:0], sub_res.ge};

  // operand mux onto the shared unit
  always_comb begin
    case (state)
      ST_DIV: begin
        sub_a = rest;
        sub_b = dsr;
      end
      ST_YEAR: begin
        sub_a = {{(SECS_W-DAYS_W){1'b0}}, days};
        sub_b = {{(SECS_W-DAYS_W){1'b0}}, (leap ? LEAP_LEN : YEAR_LEN)};
      end
      ST_MONTH: begin
        sub_a = {{(SECS_W-DAYS_W){1'b0}}, days};
        sub_b = {{(SECS_W-5){1'b0}}, month_len(mon, leap)};
      end
      default: begin
        sub_a = {{(SECS_W-DAYS_W){1'b0}}, days};
        sub_b = '0;
      end
    endcase
  end

  // December is never tested: whatever is left falls in it
  assign month_done = (mon == MON_DEC) || !sub_res.ge;
  assign out_free   = !date_valid || !date_stall;
  assign time_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      date_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (time_valid) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (cnt == 4'd0 && phase == PH_WDAY) begin
            state <= ST_YEAR;
          end
        end
        ST_YEAR: begin
          if (!sub_res.ge) begin
            state <= ST_MONTH;
          end
        end
        ST_MONTH: begin
          // hold here if the previous result has not been taken yet
          if (month_done && out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (state == ST_MONTH && month_done && out_free) begin
        date_valid <= 1'b1;
      end else if (!date_stall) begin
        date_valid <= 1'b0;
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        rest  <= epoch_seconds;
        dsr   <= STEP_DAY;
        cnt   <= 4'(N_DAY - 1);
        phase <= PH_DAY;
      end
      ST_DIV: begin
        quo <= quo_next;
        if (cnt != 4'd0) begin
          rest <= rest_next;
          dsr  <= dsr >> 1;
          cnt  <= cnt - 4'd1;
        end else begin
          case (phase)
            PH_DAY: begin
              days  <= quo_next;
              rest  <= rest_next;
              dsr   <= STEP_HOUR;
              cnt   <= 4'(N_HOUR - 1);
              phase <= PH_HOUR;
            end
            PH_HOUR: begin
              work_hour <= quo_next[4:0];
              rest      <= rest_next;
              dsr       <= STEP_MIN;
              cnt       <= 4'(N_MIN - 1);
              phase     <= PH_MIN;
            end
            PH_MIN: begin
              work_min <= quo_next[5:0];
              work_sec <= rest_next[5:0];
              rest     <= {{(SECS_W-DAYS_W){1'b0}}, days + WDAY_BIAS};
              dsr      <= STEP_WDAY;
              cnt      <= 4'(N_WDAY - 1);
              phase    <= PH_WDAY;
            end
            PH_WDAY: begin
              work_wday <= rest_next[2:0] + 3'd1;
              yoff      <= '0;
            end
            default: phase <= PH_DAY;
          endcase
        end
      end
      ST_YEAR: begin
        if (sub_res.ge) begin
          days <= sub_res.diff[DAYS_W-1:0];
          yoff <= yoff + 8'd1;
        end else begin
          mon <= MON_JAN;
        end
      end
      ST_MONTH: begin
        if (!month_done) begin
          days <= sub_res.diff[DAYS_W-1:0];
          mon  <= mon + 4'd1;
        end else if (out_free) begin
          second       <= work_sec;
          minute       <= work_min;
          hour         <= work_hour;
          weekday      <= work_wday;
          year_offset  <= yoff;
          month        <= mon + 4'd1;
          day_of_month <= days[4:0] + 5'd1;
        end
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_start: assert property (@(posedge clk) disable iff (rst)
    (time_valid && !time_stall) |=>
      (state == ST_DIV && phase == PH_DAY && cnt == 4'(N_DAY - 1)))
    else $error("split did not start after a word was taken");

  a_year_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_YEAR) |-> (yoff <= YEAR_MAX_OFF))
    else $error("year search ran past 2106");

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MONTH) |-> (mon <= MON_DEC && yoff <= YEAR_MAX_OFF))
    else $error("month search ran past December");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(date_valid) |-> ($past(state) == ST_MONTH))
    else $error("result raised outside the month search");

  a_result_range: assert property (@(posedge clk) disable iff (rst)
    $rose(date_valid) |-> (second < 6'd60 && minute < 6'd60 && hour < 5'd24 &&
                           weekday != 3'd0 && month != 4'd0 && month <= 4'd12 &&
                           day_of_month != 5'd0))
    else $error("result field out of range");
`endif

endmodule

[test/tb_epoch_seconds_to_calendar.sv]
`timescale 1ns / 1ps
// Self-checking testbench for epoch_seconds_to_calendar: directed and random words, random stalls.
//
// Every accepted time word is broken into a calendar date by the predictor
// below. The expected date is queued, and each date word that leaves the
// block is checked field by field against the oldest entry in the queue.
// Both channels idle in random bursts. There are quiet stretches in each
// random test, and the last test runs with no idling at all.
module tb_epoch_seconds_to_calendar
  import esc_pkg::*;
;

  // expected date word, tagged with the seconds it came from
  typedef struct {
    logic [31:0] src_seconds;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [2:0]  weekday;
    logic [7:0]  year_offset;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
  } cal_t;

  localparam int SETTLE_CYCLES = 300;

  logic              clk;
  logic              rst;
  logic              time_valid;
  logic              time_stall;
  logic [SECS_W-1:0] epoch_seconds;
  logic              date_valid;
  logic              date_stall;
  logic [5:0]        second;
  logic [5:0]        minute;
  logic [4:0]        hour;
  logic [2:0]        weekday;
  logic [7:0]        year_offset;
  logic [3:0]        month;
  logic [4:0]        day_of_month;

  cal_t expected_dates[$];
  int   words_sent;
  int   dates_checked;
  int   error_count;
  int   latest_year_seen;
  bit   sender_idles;
  bit   receiver_idles;

  epoch_seconds_to_calendar uut (
    .clk          (clk),
    .rst          (rst),
    .time_valid   (time_valid),
    .time_stall   (time_stall),
    .epoch_seconds(epoch_seconds),
    .date_valid   (date_valid),
    .date_stall   (date_stall),
    .second       (second),
    .minute       (minute),
    .hour         (hour),
    .weekday      (weekday),
    .year_offset  (year_offset),
    .month        (month),
    .day_of_month (day_of_month)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: report failure and end the run if it hangs.
  initial begin
    #15000000;
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Calendar arithmetic
  // ---------------------------------------------------------------------

  // Gregorian rule on the full year: 2000 is leap, 2100 is not.
  function automatic bit gregorian_leap(input int unsigned yoff);
    int unsigned y;
    y = 1970 + yoff;
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned days_in_year(input int unsigned yoff);
    return gregorian_leap(yoff) ? 366 : 365;
  endfunction

  // month counts from 1 for January
  function automatic int unsigned days_in_month(input int unsigned yoff,
                                                input int unsigned mon);
    case (mon)
      2:             return gregorian_leap(yoff) ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  // Seconds since 1970 for a given date and time; used to aim stimulus.
  function automatic longint unsigned epoch_of(input int unsigned yoff,
                                               input int unsigned mon,
                                               input int unsigned day,
                                               input int unsigned hh,
                                               input int unsigned mm,
                                               input int unsigned ss);
    longint unsigned days;
    days = 0;
    for (int unsigned y = 0; y < yoff; y++) days += days_in_year(y);
    for (int unsigned m = 1; m < mon; m++) days += days_in_month(yoff, m);
    days += day - 1;
    return days * 86400 + hh * 3600 + mm * 60 + ss;
  endfunction

  // Predictor: seconds to time of day, weekday and date.
  function automatic cal_t calendar_of(input logic [31:0] secs);
    cal_t        r;
    int unsigned rest;
    int unsigned days;
    int unsigned yoff;
    int unsigned mon;
    r.src_seconds = secs;
    r.second = 6'(secs % 60);
    rest = secs / 60;
    r.minute = 6'(rest % 60);
    rest = rest / 60;
    r.hour = 5'(rest % 24);
    days = rest / 24;
    // day 0 was a Thursday, weekday 5 with Sunday as 1
    r.weekday = 3'((days + 4) % 7 + 1);
    yoff = 0;
    while (days >= days_in_year(yoff)) begin
      days -= days_in_year(yoff);
      yoff++;
    end
    mon = 1;
    while (mon < 12 && days >= days_in_month(yoff, mon)) begin
      days -= days_in_month(yoff, mon);
      mon++;
    end
    r.year_offset = 8'(yoff);
    r.month = 4'(mon);
    r.day_of_month = 5'(days + 1);
    return r;
  endfunction

  // A timestamp on or next to a month, year or leap-day boundary.
  function automatic logic [31:0] pick_calendar_edge();
    int unsigned     yoff;
    int unsigned     mon;
    int unsigned     day;
    int unsigned     last;
    int unsigned     hh;
    int unsigned     mm;
    int unsigned     ss;
    longint unsigned t;
    case ($urandom_range(0, 5))
      0:       yoff = 130;   // 2100, common century year
      1:       yoff = 30;    // 2000, leap century year
      2:       yoff = 136;   // 2106, top of the range
      default: yoff = $urandom_range(0, 135);
    endcase
    mon = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 3) : $urandom_range(1, 12);
    last = days_in_month(yoff, mon);
    case ($urandom_range(0, 3))
      0:       day = 1;
      1:       day = last;
      2:       day = last - 1;
      default: day = $urandom_range(1, last);
    endcase
    case ($urandom_range(0, 2))
      0: begin
        hh = 0; mm = 0; ss = 0;
      end
      1: begin
        hh = 23; mm = 59; ss = 59;
      end
      default: begin
        hh = $urandom_range(0, 23); mm = $urandom_range(0, 59); ss = $urandom_range(0, 59);
      end
    endcase
    t = epoch_of(yoff, mon, day, hh, mm, ss);
    // past 2106-02-07 06:28:15 the count no longer fits; land just below the top
    if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF - $urandom_range(0, 500000);
    return t[31:0];
  endfunction

  // ---------------------------------------------------------------------
  // Channels
  // ---------------------------------------------------------------------

  // Offers one time word and holds it until taken. Valid stays high on
  // return, so back-to-back words need no gap.
  task automatic send_seconds(input logic [31:0] secs);
    int gap;
    gap = (sender_idles && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
    @(negedge clk);
    if (gap != 0) begin
      time_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    time_valid <= 1'b1;
    epoch_seconds <= secs;
    @(posedge clk);
    while (time_stall) @(posedge clk);
    expected_dates.push_back(calendar_of(secs));
    words_sent++;
  endtask

  // Drops valid and holds off until every queued date has come back.
  task automatic wait_for_dates();
    @(negedge clk);
    time_valid <= 1'b0;
    while (expected_dates.size() != 0) @(negedge clk);
  endtask

  // Receiver back-pressure: date_stall raised in random bursts.
  initial begin
    int stall_left;
    stall_left = 0;
    date_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!receiver_idles) stall_left = 0;
      else if (stall_left == 0 && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 10);
      date_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got, input logic [31:0] secs);
    if (want != got) begin
      error_count++;
      $display("%0t ns: %s for seconds %0d: expected %0d, actual %0d",
               $time, field, secs, want, got);
    end
  endtask

  // Date word checker, sampled at the rising edge.
  always @(posedge clk) begin
    cal_t want;
    if (!rst && date_valid && !date_stall) begin
      if (expected_dates.size() == 0) begin
        error_count++;
        $display("%0t ns: date word with nothing expected: expected none, actual %0d-%0d-%0d",
                 $time, year_offset, month, day_of_month);
      end else begin
        want = expected_dates.pop_front();
        check_field("second",       want.second,       second,       want.src_seconds);
        check_field("minute",       want.minute,       minute,       want.src_seconds);
        check_field("hour",         want.hour,         hour,         want.src_seconds);
        check_field("weekday",      want.weekday,      weekday,      want.src_seconds);
        check_field("year_offset",  want.year_offset,  year_offset,  want.src_seconds);
        check_field("month",        want.month,        month,        want.src_seconds);
        check_field("day_of_month", want.day_of_month, day_of_month, want.src_seconds);
        dates_checked++;
        if (want.year_offset > latest_year_seen) latest_year_seen = want.year_offset;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Carries through seconds, minutes, hours and the first week.
  task automatic test_time_of_day_edges();
    send_seconds(32'd0);
    send_seconds(32'd59);
    send_seconds(32'd60);
    send_seconds(32'd3599);
    send_seconds(32'd3600);
    send_seconds(32'd86399);
    send_seconds(32'd86400);
    send_seconds(32'd604799);
  endtask

  // Leap days, year ends, and 2100 keeping a 28-day February.
  task automatic test_leap_rules();
    send_seconds(32'(epoch_of(2, 2, 29, 12, 0, 0)));
    send_seconds(32'(epoch_of(2, 12, 31, 23, 59, 59)));
    send_seconds(32'(epoch_of(30, 2, 29, 0, 0, 0)));
    send_seconds(32'(epoch_of(30, 12, 31, 23, 59, 59)));
    send_seconds(32'(epoch_of(126, 2, 29, 6, 30, 0)));
    send_seconds(32'(epoch_of(129, 12, 31, 23, 59, 59)));
    send_seconds(32'(epoch_of(130, 2, 28, 23, 59, 59)));
    send_seconds(32'(epoch_of(130, 3, 1, 0, 0, 0)));
  endtask

  // Signed-overflow instant and the very top of the 32-bit range.
  task automatic test_range_ends();
    send_seconds(32'h7FFF_FFFF);
    send_seconds(32'h8000_0000);
    send_seconds(32'(epoch_of(135, 12, 31, 23, 59, 59)));
    send_seconds(32'(epoch_of(136, 1, 1, 0, 0, 0)));
    send_seconds(32'hFFFF_FFFE);
    send_seconds(32'hFFFF_FFFF);
  endtask

  // Sender holds off until the pipe is empty, then resumes.
  task automatic test_drain_pause();
    wait_for_dates();
    send_seconds($urandom);
    send_seconds(pick_calendar_edge());
    wait_for_dates();
  endtask

  // Flat random over the whole range; first 20 of each 100 run quiet.
  task automatic test_random_timestamps(input int count);
    for (int i = 0; i < count; i++) begin
      sender_idles = (i % 100) >= 20;
      receiver_idles = (i % 100) >= 20;
      send_seconds($urandom);
    end
  endtask

  task automatic test_calendar_edges(input int count);
    for (int i = 0; i < count; i++) begin
      sender_idles = (i % 100) >= 20;
      receiver_idles = (i % 100) >= 20;
      send_seconds(pick_calendar_edge());
    end
  endtask

  // Full rate on both sides to the end.
  task automatic test_back_to_back(input int count);
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    for (int i = 0; i < count; i++)
      send_seconds($urandom_range(0, 1) ? $urandom : pick_calendar_edge());
  endtask

  initial begin
    rst = 1'b1;
    time_valid = 1'b0;
    epoch_seconds = '0;
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    words_sent = 0;
    dates_checked = 0;
    error_count = 0;
    latest_year_seen = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_time_of_day_edges();
    test_leap_rules();
    test_range_ends();
    test_drain_pause();
    test_random_timestamps(500);
    test_calendar_edges(550);
    test_back_to_back(180);

    wait_for_dates();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Converted %0d timestamps, %0d date words checked, %0d mismatches.",
             words_sent, dates_checked, error_count);
    $display("Years 1970 to %0d, leap and century Februaries, idle and full-rate traffic.",
             1970 + latest_year_seen);
    if (error_count == 0 && expected_dates.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
